// ===== design/m3i_pkg.sv =====
// Shared widths, beat types and cofactor index table for the 3x3 inverse.
// Used by every module of the block; depends on nothing.
package m3i_pkg;

	localparam int DW = 32;               // entry width
	localparam int FB = 16;               // fraction bits
	localparam int PW = 2 * DW;           // product of two entries
	localparam int CW = 2 * DW + 1;       // cofactor
	localparam int DETW = 3 * DW + 1;     // determinant
	localparam int NW = 2 * DW + 2 * FB + 1;
	localparam int UW = ((NW > DETW) ? NW : DETW) + 1;  // divider magnitudes
	localparam int NENT = 9;
	localparam int LANE_LAT = DW + 1;
	localparam int FRONT_LAT = 4;

	typedef struct packed {
		logic signed [DW-1:0] a00;
		logic signed [DW-1:0] a01;
		logic signed [DW-1:0] a02;
		logic signed [DW-1:0] a10;
		logic signed [DW-1:0] a11;
		logic signed [DW-1:0] a12;
		logic signed [DW-1:0] a20;
		logic signed [DW-1:0] a21;
		logic signed [DW-1:0] a22;
	} mat_t;

	typedef struct packed {
		logic signed [DW-1:0] r00;
		logic signed [DW-1:0] r01;
		logic signed [DW-1:0] r02;
		logic signed [DW-1:0] r10;
		logic signed [DW-1:0] r11;
		logic signed [DW-1:0] r12;
		logic signed [DW-1:0] r20;
		logic signed [DW-1:0] r21;
		logic signed [DW-1:0] r22;
		logic                 singular;
	} inv_t;

	// Status a divider lane hands to the merge stage.
	typedef struct packed {
		logic neg;
		logic sat;
		logic zero;
	} lane_stat_t;

	typedef int cof_row_t [4];

	// Cofactor c = m[A]*m[B] - m[C]*m[D], entries indexed row*3+col.
	localparam cof_row_t COF_IDX [NENT] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

endpackage

// ===== design/m3i_front.sv =====
// Front pipeline: entry products, cofactors and determinant, four stages.
// Depends on m3i_pkg.
module m3i_front (
	input  logic                         clk,
	input  logic                         en,
	input  m3i_pkg::mat_t                mat,
	output logic signed [m3i_pkg::CW-1:0]   cof [m3i_pkg::NENT],
	output logic signed [m3i_pkg::DETW-1:0] det,
	output logic [m3i_pkg::DW-1:0]          pass [m3i_pkg::NENT]
);
	import m3i_pkg::*;

	logic signed [DW-1:0]     m [NENT];
	logic signed [PW-1:0]     prod_s1 [2*NENT];
	logic signed [CW-1:0]     cof_s2 [NENT];
	logic signed [CW-1:0]     cof_s3 [NENT];
	logic signed [CW-1:0]     cof_s4 [NENT];
	logic signed [2*DW+1:0]   plo_s3 [3];
	logic signed [2*DW+1:0]   phi_s3 [3];
	logic signed [DETW-1:0]   det_s4;
	logic [DW-1:0]            m_s1 [NENT];
	logic [DW-1:0]            m_s2 [NENT];
	logic [DW-1:0]            m_s3 [NENT];
	logic [DW-1:0]            m_s4 [NENT];

	// Unpack the matrix beat, first field in the top bits.
	always_comb begin
		for (int i = 0; i < NENT; i++) begin
			m[i] = $signed(mat[(NENT-i)*DW-1 -: DW]);
		end
	end

	// Stage 1: the eighteen entry products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NENT; i++) begin
				prod_s1[2*i]   <= m[COF_IDX[i][0]] * m[COF_IDX[i][1]];
				prod_s1[2*i+1] <= m[COF_IDX[i][2]] * m[COF_IDX[i][3]];
				m_s1[i] <= m[i];
			end
		end
	end

	// Stage 2: cofactors as product differences.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NENT; i++) begin
				cof_s2[i] <= CW'(prod_s1[2*i]) - CW'(prod_s1[2*i+1]);
				m_s2[i] <= m_s1[i];
			end
		end
	end

	// Stage 3: first-row entries times cofactor halves.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= (2*DW+2)'($signed(m_s2[j]) *
					$signed({1'b0, cof_s2[3*j][DW-1:0]}));
				phi_s3[j] <= (2*DW+2)'($signed(m_s2[j]) * $signed(cof_s2[3*j][CW-1:DW]));
			end
			for (int i = 0; i < NENT; i++) begin
				cof_s3[i] <= cof_s2[i];
				m_s3[i] <= m_s2[i];
			end
		end
	end

	// Stage 4: determinant along the first row.
	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= ((DETW'(phi_s3[0]) + DETW'(phi_s3[1]) + DETW'(phi_s3[2])) <<< DW)
				+ DETW'(plo_s3[0]) + DETW'(plo_s3[1]) + DETW'(plo_s3[2]);
			for (int i = 0; i < NENT; i++) begin
				cof_s4[i] <= cof_s3[i];
				m_s4[i] <= m_s3[i];
			end
		end
	end

	assign cof = cof_s4;
	assign det = det_s4;
	assign pass = m_s4;

endmodule

// ===== design/m3i_lane.sv =====
// One divider lane: rounded cofactor / determinant, one quotient bit a stage.
// Depends on m3i_pkg.
module m3i_lane (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [m3i_pkg::CW-1:0]   cof,
	input  logic signed [m3i_pkg::DETW-1:0] det,
	input  logic [m3i_pkg::DW-1:0]          pass,
	output logic [m3i_pkg::DW-2:0]          quo,
	output m3i_pkg::lane_stat_t             stat,
	output logic [m3i_pkg::DW-1:0]          pass_out
);
	import m3i_pkg::*;

	logic [UW-1:0] cof_ext, det_ext, cof_mag, det_mag;
	logic [UW-1:0] rem_s [LANE_LAT];
	logic [UW-1:0] den_s [LANE_LAT];
	logic [DW-2:0] q_s [LANE_LAT];
	lane_stat_t    stat_s [LANE_LAT];
	logic [DW-1:0] pass_s [LANE_LAT];

	// Magnitudes; numerator carries the rounding half.
	always_comb begin
		cof_ext = {{(UW-CW){cof[CW-1]}}, cof};
		det_ext = {{(UW-DETW){det[DETW-1]}}, det};
		cof_mag = cof[CW-1] ? (~cof_ext + 1'b1) : cof_ext;
		det_mag = det[DETW-1] ? (~det_ext + 1'b1) : det_ext;
	end

	// Stage 0: operands of the long division.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= (cof_mag << (2*FB+1)) + det_mag;
			den_s[0] <= det_mag << 1;
			q_s[0] <= '0;
			stat_s[0].neg <= cof[CW-1] ^ det[DETW-1];
			stat_s[0].zero <= (det == '0);
			stat_s[0].sat <= 1'b0;
			pass_s[0] <= pass;
		end
	end

	// Stage 1: saturation when the quotient reaches the sign bit.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[1] <= rem_s[0];
			den_s[1] <= den_s[0];
			q_s[1] <= q_s[0];
			stat_s[1].neg <= stat_s[0].neg;
			stat_s[1].zero <= stat_s[0].zero;
			stat_s[1].sat <= {{DW{1'b0}}, rem_s[0]} >= ({{DW{1'b0}}, den_s[0]} << (DW-1));
			pass_s[1] <= pass_s[0];
		end
	end

	// Remaining stages: restoring division, most significant bit first.
	for (genvar i = 2; i < LANE_LAT; i++) begin : g_div
		localparam int K = LANE_LAT - 1 - i;
		logic [UW+DW-1:0] dsh;
		logic             take;
		assign dsh = {{DW{1'b0}}, den_s[i-1]} << K;
		assign take = {{DW{1'b0}}, rem_s[i-1]} >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? rem_s[i-1] - dsh[UW-1:0] : rem_s[i-1];
				den_s[i] <= den_s[i-1];
				q_s[i] <= q_s[i-1] | ((DW-1)'(take) << K);
				stat_s[i] <= stat_s[i-1];
				pass_s[i] <= pass_s[i-1];
			end
		end
	end

	assign quo = q_s[LANE_LAT-1];
	assign stat = stat_s[LANE_LAT-1];
	assign pass_out = pass_s[LANE_LAT-1];

endmodule

// ===== design/mat3_inverse.sv =====
// Top level of the 3x3 fixed-point matrix inverse: front, nine lanes, merge.
// Depends on m3i_pkg, m3i_front and m3i_lane.
//
//  channel | valid     | stall     | beat | carries
//  input   | mat_valid | mat_stall | mat  | matrix a00..a22, Q16.16
//  output  | inv_valid | inv_stall | inv  | inverse r00..r22 and singular
//
// One matrix is taken every cycle while no result waits under inv_stall; the path of
// each result is mostly the 31 restoring-division stages of each lane.
// Reset clears only the valid pipeline; no clearing pass is needed.
// The whole pipeline holds while a result waits under inv_stall.
module mat3_inverse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            mat_valid,
	output logic            mat_stall,
	input  m3i_pkg::mat_t   mat,
	output logic            inv_valid,
	input  logic            inv_stall,
	output m3i_pkg::inv_t   inv
);
	import m3i_pkg::*;

	localparam int LAT = FRONT_LAT + LANE_LAT;

	logic                   en;
	logic [LAT-1:0]         vld_q;
	logic                   inv_valid_q;
	inv_t                   inv_q;
	logic signed [CW-1:0]   cof [NENT];
	logic signed [DETW-1:0] det;
	logic [DW-1:0]          pass [NENT];
	logic [DW-2:0]          quo [NENT];
	lane_stat_t             stat [NENT];
	logic [DW-1:0]          pass_l [NENT];
	logic [DW-1:0]          val [NENT];

	assign en = !inv_valid_q || !inv_stall;
	assign mat_stall = !en;

	m3i_front u_front (
		.clk(clk), .en(en), .mat(mat), .cof(cof), .det(det), .pass(pass)
	);

	for (genvar i = 0; i < NENT; i++) begin : g_lane
		m3i_lane u_lane (
			.clk(clk), .en(en), .cof(cof[i]), .det(det), .pass(pass[i]),
			.quo(quo[i]), .stat(stat[i]), .pass_out(pass_l[i])
		);
	end

	// Merge: sign, saturation and pass-through of a singular matrix.
	always_comb begin
		for (int i = 0; i < NENT; i++) begin
			if (stat[0].zero) begin
				val[i] = pass_l[i];
			end else if (stat[i].sat) begin
				val[i] = stat[i].neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
			end else begin
				val[i] = stat[i].neg ? (~{1'b0, quo[i]} + 1'b1) : {1'b0, quo[i]};
			end
		end
	end

	// Valid pipeline and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			inv_valid_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], mat_valid};
			inv_valid_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_q <= {val[0], val[1], val[2], val[3], val[4], val[5], val[6], val[7],
				val[8], stat[0].zero};
		end
	end

	assign inv_valid = inv_valid_q;
	assign inv = inv_q;

endmodule

// ===== design/m3i_checker.sv =====
// Port-level checks for the 3x3 inverse and the bind that attaches them.
// Depends on m3i_pkg and mat3_inverse.
module m3i_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          mat_valid,
	input logic          mat_stall,
	input m3i_pkg::mat_t mat,
	input logic          inv_valid,
	input logic          inv_stall,
	input m3i_pkg::inv_t inv
);
	import m3i_pkg::*;

	// A stalled result beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv_stall |=> inv_valid && $stable(inv))
		else $error("stalled result beat changed");

	// Input is held off only by a waiting result.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		mat_stall |-> inv_valid && inv_stall)
		else $error("input stalled without a waiting result");

	// A cycle in reset leaves the output empty.
	a_reset: assert property (@(posedge clk) !arst_n |=> !inv_valid)
		else $error("result valid after reset");

endmodule

bind mat3_inverse m3i_checker u_m3i_checker (.*);
